>>> hdl/tcw_pkg.sv
package tcw_pkg;

    // Field widths of the channels
    localparam int KIND_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int ENTRY_W = 16;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int COLOR_W = 8;

    // Address width of the memory request, sized for the largest screen (32 x 128)
    localparam int RAM_AW = 12;

    localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
    localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
    localparam logic [ENTRY_W-1:0] INIT_CELL    = 16'h0720;
    localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h07;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic               cell_written;
        logic [IDX_W-1:0]   cell_index;
        logic [ENTRY_W-1:0] cell_entry;
        logic               scrolled;
        logic [IDX_W-1:0]   cursor_pos;
        logic [ROW_W-1:0]   cursor_row;
        logic [COL_W-1:0]   cursor_col;
        logic [ENTRY_W-1:0] read_entry;
    } t_result;

    typedef struct packed {
        logic               we;
        logic [RAM_AW-1:0]  waddr;
        logic [ENTRY_W-1:0] wdata;
        logic               re;
        logic [RAM_AW-1:0]  raddr;
    } t_ram_req;

endpackage

>>> hdl/tcw_cfg_if.sv
interface tcw_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::COLOR_W-1:0]   text_color;

    modport source (output valid, output text_color, input ready);
    modport sink   (input valid, input text_color, output ready);
endinterface

>>> hdl/tcw_in_if.sv
interface tcw_in_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::KIND_W-1:0]    kind;
    logic [tcw_pkg::CHAR_W-1:0]    char_code;
    logic [tcw_pkg::IDX_W-1:0]     read_index;

    modport source (output valid, output kind, output char_code, output read_index,
                    input ready);
    modport sink   (input valid, input kind, input char_code, input read_index,
                    output ready);
endinterface

>>> hdl/tcw_out_if.sv
interface tcw_out_if;
    logic                          valid;
    logic                          ready;
    logic                          cell_written;
    logic [tcw_pkg::IDX_W-1:0]     cell_index;
    logic [tcw_pkg::ENTRY_W-1:0]   cell_entry;
    logic                          scrolled;
    logic [tcw_pkg::IDX_W-1:0]     cursor_pos;
    logic [tcw_pkg::ROW_W-1:0]     cursor_row;
    logic [tcw_pkg::COL_W-1:0]     cursor_col;
    logic [tcw_pkg::ENTRY_W-1:0]   read_entry;

    modport source (output valid, output cell_written, output cell_index,
                    output cell_entry, output scrolled, output cursor_pos,
                    output cursor_row, output cursor_col, output read_entry,
                    input ready);
    modport sink   (input valid, input cell_written, input cell_index,
                    input cell_entry, input scrolled, input cursor_pos,
                    input cursor_row, input cursor_col, input read_entry,
                    output ready);
endinterface

>>> hdl/tcw_cell_ram.sv
module tcw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                          i_clk,
    input  tcw_pkg::t_ram_req             i_req,
    output logic [tcw_pkg::ENTRY_W-1:0]   o_rdata
);
    import tcw_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/tcw_ctrl.sv
module tcw_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tcw_pkg::COLOR_W-1:0]   i_text_color,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tcw_pkg::KIND_W-1:0]    i_kind,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tcw_pkg::IDX_W-1:0]     i_read_index,
    input  logic                          i_out_free,
    output logic                          o_res_valid,
    output tcw_pkg::t_result              o_res,
    output tcw_pkg::t_ram_req             o_ram_req,
    input  logic [tcw_pkg::ENTRY_W-1:0]   i_rdata
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam logic [AW-1:0] LAST_BASE = AW'(CELLS - COLUMNS);

    t_state             r_state, n_state;
    logic [RW-1:0]      r_row, n_row;
    logic [CW-1:0]      r_col, n_col;
    logic [AW-1:0]      r_pos, n_pos;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_cp_pend, n_cp_pend;
    logic               r_rd_ok, n_rd_ok;
    logic [AW-1:0]      r_wa, n_wa;
    t_result            r_res, n_res;

    logic               newline;
    logic [AW-1:0]      line_next;

    // start of the next line, valid when not on the bottom row
    assign line_next = r_pos - AW'(r_col) + AW'(COLUMNS);

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_cp_pend   = r_cp_pend;
        n_rd_ok     = r_rd_ok;
        n_wa        = r_wa;
        n_res       = r_res;
        newline     = 1'b0;
        o_ram_req   = '0;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_res       = r_res;

        case (r_state)
            ST_INIT: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = RAM_AW'(r_idx[AW-1:0]);
                o_ram_req.wdata = INIT_CELL;
                if (r_idx == CNT_W'(CELLS - 1)) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_res   = '0;
                    n_state = ST_RESULT;
                    case (i_kind)
                        KIND_PUT: begin
                            if (i_char_code == NEWLINE_CHAR) begin
                                newline = 1'b1;
                            end else begin
                                o_ram_req.we       = 1'b1;
                                o_ram_req.waddr    = RAM_AW'(r_pos);
                                o_ram_req.wdata    = {i_text_color, i_char_code};
                                n_res.cell_written = 1'b1;
                                n_res.cell_index   = IDX_W'(r_pos);
                                n_res.cell_entry   = {i_text_color, i_char_code};
                                if (r_col == CW'(COLUMNS - 1)) begin
                                    newline = 1'b1;
                                end else begin
                                    n_col = r_col + 1'b1;
                                    n_pos = r_pos + 1'b1;
                                end
                            end
                            if (newline) begin
                                n_col = '0;
                                if (r_row == RW'(ROWS - 1)) begin
                                    // bottom row: copy rows up, then blank the last one
                                    n_pos          = LAST_BASE;
                                    n_res.scrolled = 1'b1;
                                    n_idx          = CNT_W'(COLUMNS);
                                    n_cp_pend      = 1'b0;
                                    n_state        = ST_SCROLL;
                                end else begin
                                    n_row = r_row + 1'b1;
                                    n_pos = line_next;
                                end
                            end
                        end
                        KIND_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_pos   = '0;
                            n_idx   = '0;
                            n_state = ST_FILL;
                        end
                        KIND_READ: begin
                            o_ram_req.re    = 1'b1;
                            o_ram_req.raddr = RAM_AW'(i_read_index);
                            n_rd_ok         = (32'(i_read_index) < 32'(CELLS));
                            n_state         = ST_READ;
                        end
                        default: begin
                            n_state = ST_RESULT;
                        end
                    endcase
                    n_res.cursor_pos = IDX_W'(n_pos);
                    n_res.cursor_row = ROW_W'(n_row);
                    n_res.cursor_col = COL_W'(n_col);
                end
            end
            ST_READ: begin
                n_res.read_entry = r_rd_ok ? i_rdata : '0;
                n_state          = ST_RESULT;
            end
            ST_SCROLL: begin
                // read cell i, write it one line up in the next cycle
                if (r_cp_pend) begin
                    o_ram_req.we    = 1'b1;
                    o_ram_req.waddr = RAM_AW'(r_wa);
                    o_ram_req.wdata = i_rdata;
                end
                if (r_idx != CNT_W'(CELLS)) begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = RAM_AW'(r_idx[AW-1:0]);
                    n_wa            = r_idx[AW-1:0] - AW'(COLUMNS);
                    n_cp_pend       = 1'b1;
                    n_idx           = r_idx + 1'b1;
                end else begin
                    n_cp_pend = 1'b0;
                    n_idx     = CNT_W'(CELLS - COLUMNS);
                    n_state   = ST_FILL;
                end
            end
            ST_FILL: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = RAM_AW'(r_idx[AW-1:0]);
                o_ram_req.wdata = {i_text_color, BLANK_CHAR};
                if (r_idx == CNT_W'(CELLS - 1)) begin
                    n_idx   = '0;
                    n_state = ST_RESULT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_RESULT: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_row     <= '0;
            r_col     <= '0;
            r_pos     <= '0;
            r_idx     <= '0;
            r_cp_pend <= 1'b0;
            r_rd_ok   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_col     <= n_col;
            r_pos     <= n_pos;
            r_idx     <= n_idx;
            r_cp_pend <= n_cp_pend;
            r_rd_ok   <= n_rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa  <= n_wa;
        r_res <= n_res;
    end

endmodule

>>> hdl/text_console_writer_top.sv
// Channel   Dir  Handshake        Payload
// i_cfg     in   valid / ready    text_color (attribute for new cells and blanks)
// i_in      in   valid / ready    kind, char_code, read_index
// o_out     out  valid / ready    cell_written, cell_index, cell_entry, scrolled,
//                                 cursor_pos, cursor_row, cursor_col, read_entry
//
// A clear or a scroll walks the cell memory; the copy and the blank fill go one entry
// a cycle through its single write port.
// After reset the memory is swept to blank grey; i_in stays not ready during the
// sweep, i_cfg is always ready.
// A finished result waits in the output register while the next item is being worked.
module text_console_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tcw_cfg_if.sink          i_cfg,
    tcw_in_if.sink           i_in,
    tcw_out_if.source        o_out
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    logic [COLOR_W-1:0] r_text_color;
    logic               r_out_valid;
    t_result            r_out;

    logic               out_free;
    logic               res_valid;
    t_result            res;
    t_ram_req           ram_req;
    logic [ENTRY_W-1:0] ram_rdata;

    // Color register: written any time the host asks, used for puts and blank fills
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= COLOR_RESET;
        end else if (i_cfg.valid) begin
            r_text_color <= i_cfg.text_color;
        end
    end

    // Output register is free when empty or drained this cycle
    assign out_free = !r_out_valid || o_out.ready;

    tcw_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text_color (r_text_color),
        .i_in_valid   (i_in.valid),
        .o_in_ready   (i_in.ready),
        .i_kind       (i_in.kind),
        .i_char_code  (i_in.char_code),
        .i_read_index (i_in.read_index),
        .i_out_free   (out_free),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_ram_req    (ram_req),
        .i_rdata      (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.cell_written = r_out.cell_written;
    assign o_out.cell_index   = r_out.cell_index;
    assign o_out.cell_entry   = r_out.cell_entry;
    assign o_out.scrolled     = r_out.scrolled;
    assign o_out.cursor_pos   = r_out.cursor_pos;
    assign o_out.cursor_row   = r_out.cursor_row;
    assign o_out.cursor_col   = r_out.cursor_col;
    assign o_out.read_entry   = r_out.read_entry;

    // A result is only handed over when the output register can take it
    a_res_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> out_free)
        else $error("result pushed into a full output register");

    // Items are taken only when no result is being handed over
    a_accept_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> !res_valid)
        else $error("item accepted while a result is handed over");

    // Reported cursor stays on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.cursor_row < ROWS) && (o_out.cursor_col < COLUMNS))
        else $error("cursor reported off screen");

    // A scroll leaves the cursor at the start of the bottom row
    a_scroll_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.scrolled) |->
            (o_out.cursor_row == ROW_W'(ROWS - 1)) && (o_out.cursor_col == '0))
        else $error("scroll without cursor at bottom row start");

endmodule

>>> bench/tcw_checker.sv
module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tcw_cfg_if   i_cfg,
    tcw_in_if    i_in,
    tcw_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int CELLS       = ROWS * COLUMNS;
    localparam int MAX_REPORTS = 10;

    // Shadow copy of the console state
    logic [ENTRY_W-1:0] screen [CELLS];
    int                 row_at;
    int                 col_at;
    logic [COLOR_W-1:0] attr;

    t_result expected_results [$];
    int      mismatches = 0;

    function automatic logic [ENTRY_W-1:0] blank_entry();
        return {attr, BLANK_CHAR};
    endfunction

    // Cursor to start of next line; scrolls when it runs off the bottom.
    function automatic logic line_feed();
        col_at = 0;
        row_at++;
        if (row_at < ROWS) begin
            return 1'b0;
        end
        for (int i = 0; i < CELLS - COLUMNS; i++) begin
            screen[i] = screen[i + COLUMNS];
        end
        for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen[i] = blank_entry();
        end
        row_at = ROWS - 1;
        return 1'b1;
    endfunction

    function automatic t_result console_step(input logic [KIND_W-1:0]  kind,
                                             input logic [CHAR_W-1:0]  ch,
                                             input logic [IDX_W-1:0]   idx);
        t_result r;
        int      cell_at;
        r = '0;
        case (kind)
            KIND_PUT: begin
                if (ch == NEWLINE_CHAR) begin
                    r.scrolled = line_feed();
                end else begin
                    cell_at         = row_at * COLUMNS + col_at;
                    r.cell_written  = 1'b1;
                    r.cell_index    = IDX_W'(cell_at);
                    r.cell_entry    = {attr, ch};
                    screen[cell_at] = r.cell_entry;
                    col_at++;
                    if (col_at >= COLUMNS) begin
                        r.scrolled = line_feed();
                    end
                end
            end
            KIND_CLEAR: begin
                for (int i = 0; i < CELLS; i++) begin
                    screen[i] = blank_entry();
                end
                row_at = 0;
                col_at = 0;
            end
            KIND_READ: begin
                if (int'(idx) < CELLS) begin
                    r.read_entry = screen[idx];
                end
            end
            default: ;  // unused kind: cursor only
        endcase
        r.cursor_pos = IDX_W'(row_at * COLUMNS + col_at);
        r.cursor_row = ROW_W'(row_at);
        r.cursor_col = COL_W'(col_at);
        return r;
    endfunction

    function automatic string show_result(input t_result r);
        return $sformatf("wr=%0d idx=%0d cell=%h scr=%0d pos=%0d row=%0d col=%0d rd=%h",
                         r.cell_written, r.cell_index, r.cell_entry, r.scrolled,
                         r.cursor_pos, r.cursor_row, r.cursor_col, r.read_entry);
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                screen[i] = INIT_CELL;
            end
            row_at = 0;
            col_at = 0;
            attr   = COLOR_RESET;
            expected_results.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                attr = i_cfg.text_color;
            end
            if (i_in.valid && i_in.ready) begin
                expected_results.push_back(
                    console_step(i_in.kind, i_in.char_code, i_in.read_index));
            end
            if (i_out.valid && i_out.ready) begin
                got = {i_out.cell_written, i_out.cell_index, i_out.cell_entry,
                       i_out.scrolled, i_out.cursor_pos, i_out.cursor_row,
                       i_out.cursor_col, i_out.read_entry};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%t: result with nothing pending: %s", $realtime,
                                 show_result(got));
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("%t: result mismatch", $realtime);
                            $display("    expected %s", show_result(want));
                            $display("    actual   %s", show_result(got));
                        end
                    end
                end
            end
        end
        o_pending    = expected_results.size();
        o_fail_count = mismatches;
    end

endmodule

>>> bench/text_console_writer_top_test.sv
module text_console_writer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    // Kind code the block leaves unused; it must answer with the cursor only
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Longest quiet stretch: a scroll or clear walks all cells, plus the
    // post-reset sweep and the receiver hold-off. Several times over.
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 370;
    localparam int DRAIN_CYCLES    = 20;

    logic clk;
    logic rst_n;

    tcw_cfg_if cfg_ch ();
    tcw_in_if  in_ch ();
    tcw_out_if out_ch ();

    int fail_count;
    int pending;

    // Knobs for the sender and receiver (written by the main sequence), plus the item and watchdog counts
    int send_idle_pct;
    int stall_pct;
    bit hold_off_req;
    int items_sent;
    int quiet_cycles;

    text_console_writer_top #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    tcw_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) console_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg        (cfg_ch),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one item. Entered and left at a falling edge. valid is left high after
    // the handshake so that back-to-back items never lower and raise it in one step;
    // an idle gap (or drain) is what takes it down.
    task automatic send_item(input logic [KIND_W-1:0] kind,
                             input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0]  idx);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.char_code  <= ch;
        in_ch.read_index <= idx;
        @(posedge clk);
        while (!in_ch.ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        if (kind != KIND_UNUSED) begin
            items_sent++;
        end
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    // Color change; only called with the block idle.
    task automatic write_color(input logic [COLOR_W-1:0] color);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.text_color <= color;
        @(posedge clk);
        while (!cfg_ch.ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // A run of items with a given newline density:
    //   low  -> long lines that wrap at the last column
    //   mid  -> ordinary text
    //   high -> many line feeds, keeps the cursor on the bottom row and scrolling
    // Clears are kept rare since each one walks the whole store.
    task automatic random_burst(input int newline_pct, input int length);
        int                  pick;
        logic [CHAR_W-1:0]   ch;
        logic [IDX_W-1:0]    idx;
        for (int n = 0; n < length; n++) begin
            pick = $urandom_range(99);
            if (pick < 1) begin
                send_item(KIND_CLEAR, CHAR_W'($urandom), IDX_W'($urandom_range(2047)));
            end else if (pick < 4) begin
                send_item(KIND_UNUSED, CHAR_W'($urandom), IDX_W'($urandom_range(2047)));
            end else if (pick < 18) begin
                // half anywhere (incl. past the end), half on the bottom row
                if ($urandom_range(1) == 0) begin
                    idx = IDX_W'($urandom_range(2047));
                end else begin
                    idx = IDX_W'($urandom_range(CELLS - 1, CELLS - COLUMNS));
                end
                send_item(KIND_READ, CHAR_W'($urandom), idx);
            end else begin
                if ($urandom_range(99) < newline_pct) begin
                    ch = NEWLINE_CHAR;
                end else begin
                    ch = CHAR_W'($urandom);
                end
                send_item(KIND_PUT, ch, IDX_W'($urandom_range(2047)));
            end
        end
    endtask

    // Receiver: random stalls per stall_pct, plus one long hold-off on request
    // while the sender keeps pushing, so the block backs up and stalls its input.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_off_req && !hold_done) begin
                hold_left    = HOLD_CYCLES - 1;
                hold_done    = 1'b1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog: any cycle with no handshake on any channel counts toward the limit.
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int                 newline_mix [3];
        logic [COLOR_W-1:0] color;
        newline_mix = '{1, 12, 45};

        rst_n             = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.text_color = '0;
        in_ch.valid       = 1'b0;
        in_ch.kind        = KIND_PUT;
        in_ch.char_code   = '0;
        in_ch.read_index  = '0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        hold_off_req      = 1'b0;
        items_sent        = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset contents and color, range edges of the read index,
        // character extremes, newline, unused kind, readback, clear.
        // The input stays blocked during the post-reset sweep; send_item just waits.
        send_item(KIND_READ, 8'h00, 11'd0);
        send_item(KIND_READ, 8'hFF, IDX_W'(CELLS - 1));
        send_item(KIND_READ, 8'h00, IDX_W'(CELLS));          // just past the end
        send_item(KIND_READ, 8'hFF, 11'h7FF);                // far past the end
        send_item(KIND_PUT,  8'h00, 11'h7FF);
        send_item(KIND_PUT,  8'hFF, 11'd0);
        send_item(KIND_PUT,  8'h41, 11'd0);
        send_item(KIND_PUT,  NEWLINE_CHAR, 11'd0);
        send_item(KIND_UNUSED, 8'hFF, 11'h7FF);
        send_item(KIND_READ, 8'h00, 11'd0);
        send_item(KIND_READ, 8'h00, 11'd1);
        send_item(KIND_READ, 8'h00, 11'd2);
        send_item(KIND_PUT,  8'h5A, 11'd0);
        send_item(KIND_READ, 8'h00, IDX_W'(COLUMNS));
        send_item(KIND_CLEAR, 8'hFF, 11'h7FF);
        send_item(KIND_READ, 8'h00, 11'd0);
        send_item(KIND_READ, 8'h00, IDX_W'(COLUMNS + 1));

        // Random phases: no idling, sender idle, receiver stall, both.
        // Each starts from idle with a new color, extremes first.
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  color = 8'hFF; end
                1: begin send_idle_pct = 76; stall_pct = 0;  color = 8'h00; end
                2: begin send_idle_pct = 0;  stall_pct = 76; color = COLOR_W'($urandom); end
                default: begin
                    send_idle_pct = 36;
                    stall_pct     = 36;
                    color         = COLOR_W'($urandom);
                end
            endcase
            write_color(color);
            if (ph == 0) begin
                hold_off_req = 1'b1;   // back-pressure while traffic runs flat out
            end
            items_sent = 0;
            while (items_sent < ITEMS_PER_PHASE) begin
                random_burst(newline_mix[$urandom_range(2)], $urandom_range(40, 10));
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
